@@ rtl/fbde_pkg.sv @@
`default_nettype none
package fbde_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 512;
    localparam int unsigned DEF_MAX_HEIGHT = 512;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_SET   = 3'd1,
        OP_READ  = 3'd2,
        OP_HLINE = 3'd3,
        OP_VLINE = 3'd4,
        OP_VXOR  = 3'd5,
        OP_RECT  = 3'd6,
        OP_BAD   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        KIND_DONE,
        KIND_REJECT,
        KIND_SPAN,
        KIND_READ
    } kind_t;

    // classified job: a run of rows x cols pixels starting at (col0,row0)
    typedef struct packed {
        kind_t       kind;
        logic        xor_mode;
        logic [12:0] col0;
        logic [12:0] row0;
        logic [12:0] cols;
        logic [12:0] rows;
        logic [31:0] color;
    } job_t;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_RUN,
        BE_XRD,
        BE_XWR
    } be_state_t;

endpackage
`default_nettype wire

@@ rtl/fbde_front.sv @@
`default_nettype none
module fbde_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [2:0]    opcode,
    input  wire logic [8:0]    pos_x,
    input  wire logic [8:0]    pos_y,
    input  wire logic [8:0]    end_coord,
    input  wire logic [9:0]    rect_width,
    input  wire logic [9:0]    rect_height,
    input  wire logic [31:0]   color,
    input  wire logic [12:0]   img_w,
    input  wire logic [12:0]   img_h,
    output fbde_pkg::job_t     job,
    output logic               job_valid,
    input  wire logic          job_taken
);
    import fbde_pkg::*;

    job_t job_reg, job_next;
    logic valid_reg;
    logic [13:0] x, y, e, rw, rh, w, h;

    always_comb
    begin
        x = {5'd0, pos_x};
        y = {5'd0, pos_y};
        e = {5'd0, end_coord};
        rw = {4'd0, rect_width};
        rh = {4'd0, rect_height};
        w = {1'b0, img_w};
        h = {1'b0, img_h};
        job_next = '0;
        job_next.color = color;
        job_next.kind = KIND_DONE;
        unique case (op_t'(opcode))
            OP_CLEAR:
            begin
                job_next.kind = KIND_SPAN;
                job_next.cols = img_w;
                job_next.rows = img_h;
            end
            OP_SET, OP_READ:
            begin
                job_next.col0 = x[12:0];
                job_next.row0 = y[12:0];
                job_next.cols = 13'd1;
                job_next.rows = 13'd1;
                if (x >= w || y >= h)
                    job_next.kind = KIND_REJECT;
                else
                    job_next.kind = (op_t'(opcode) == OP_READ) ? KIND_READ : KIND_SPAN;
            end
            OP_HLINE:
            begin
                job_next.col0 = x[12:0];
                job_next.row0 = y[12:0];
                job_next.cols = 13'(e - x + 14'd1);
                job_next.rows = 13'd1;
                if (x > e)
                    job_next.kind = KIND_DONE;
                else if (e >= w || y >= h)
                    job_next.kind = KIND_REJECT;
                else
                    job_next.kind = KIND_SPAN;
            end
            OP_VLINE, OP_VXOR:
            begin
                job_next.col0 = x[12:0];
                job_next.row0 = y[12:0];
                job_next.cols = 13'd1;
                job_next.rows = 13'(e - y + 14'd1);
                job_next.xor_mode = (op_t'(opcode) == OP_VXOR);
                if (y > e)
                    job_next.kind = KIND_DONE;
                else if (x >= w || e >= h)
                    job_next.kind = KIND_REJECT;
                else
                    job_next.kind = KIND_SPAN;
            end
            OP_RECT:
            begin
                job_next.col0 = x[12:0];
                job_next.row0 = y[12:0];
                job_next.cols = rw[12:0];
                job_next.rows = rh[12:0];
                if (rw == '0 || rh == '0)
                    job_next.kind = KIND_DONE;
                else if (x + rw > w || y + rh > h)
                    job_next.kind = KIND_REJECT;
                else
                    job_next.kind = KIND_SPAN;
            end
            OP_BAD:
                job_next.kind = KIND_REJECT;
            default:
                job_next.kind = KIND_REJECT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_valid)
            valid_reg <= 1'b1;
        else if (job_taken)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            job_reg <= job_next;
    end

    assign job = job_reg;
    assign job_valid = valid_reg;
endmodule
`default_nettype wire

@@ rtl/fbde_back.sv @@
`default_nettype none
module fbde_back #(
    parameter int unsigned MAX_WIDTH  = fbde_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = fbde_pkg::DEF_MAX_HEIGHT,
    parameter int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fbde_pkg::job_t job,
    input  wire logic          job_valid,
    output logic               job_taken,
    input  wire logic [12:0]   img_w,
    output logic               done,
    output logic [31:0]        pixel_value,
    output logic               status
);
    import fbde_pkg::*;

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    be_state_t state_reg, state_next;
    job_t cur_reg;
    logic [12:0] ci_reg, ci_next, ri_reg, ri_next;
    logic [25:0] rowbase_reg, rowbase_next;
    logic [25:0] addr;
    logic we, re;
    logic [31:0] wdata;
    logic is_read_reg, rd_pend_reg;
    logic done_reg, stat_reg;
    logic load;
    logic [25:0] start_base;

    assign addr = rowbase_reg + {13'd0, ci_reg};
    assign start_base = 26'(job.row0 * img_w) + {13'd0, job.col0};

    always_comb
    begin
        state_next = state_reg;
        ci_next = ci_reg;
        ri_next = ri_reg;
        rowbase_next = rowbase_reg;
        we = 1'b0;
        re = 1'b0;
        wdata = cur_reg.color;
        job_taken = 1'b0;
        load = 1'b0;
        unique case (state_reg)
            BE_IDLE:
            begin
                if (job_valid)
                begin
                    job_taken = 1'b1;
                    if (job.kind == KIND_SPAN || job.kind == KIND_READ)
                    begin
                        load = 1'b1;
                        ci_next = '0;
                        ri_next = '0;
                        rowbase_next = start_base;
                        state_next = job.xor_mode ? BE_XRD : BE_RUN;
                    end
                end
            end
            BE_RUN:
            begin
                if (cur_reg.kind == KIND_READ)
                    re = 1'b1;
                else
                    we = 1'b1;
                if (ci_reg + 13'd1 < cur_reg.cols)
                    ci_next = ci_reg + 13'd1;
                else
                begin
                    ci_next = '0;
                    rowbase_next = rowbase_reg + {13'd0, img_w};
                    if (ri_reg + 13'd1 < cur_reg.rows)
                        ri_next = ri_reg + 13'd1;
                    else
                        state_next = BE_IDLE;
                end
            end
            BE_XRD:
            begin
                re = 1'b1;
                state_next = BE_XWR;
            end
            BE_XWR:
            begin
                we = 1'b1;
                wdata = rdata_reg ^ cur_reg.color;
                rowbase_next = rowbase_reg + {13'd0, img_w};
                if (ri_reg + 13'd1 < cur_reg.rows)
                begin
                    ri_next = ri_reg + 13'd1;
                    state_next = BE_XRD;
                end
                else
                    state_next = BE_IDLE;
            end
            default:
                state_next = BE_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr[AW-1:0]] <= wdata;
        if (re)
            rdata_reg <= mem[addr[AW-1:0]];
        if (load)
            cur_reg <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_IDLE;
            ci_reg <= '0;
            ri_reg <= '0;
            rowbase_reg <= '0;
            done_reg <= 1'b0;
            stat_reg <= 1'b0;
            is_read_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ci_reg <= ci_next;
            ri_reg <= ri_next;
            rowbase_reg <= rowbase_next;
            // report at the end of each job; a read reports after its access, through rd_pend_reg and then done_reg
            rd_pend_reg <= (state_reg == BE_RUN) && (cur_reg.kind == KIND_READ);
            done_reg <= 1'b0;
            stat_reg <= 1'b0;
            is_read_reg <= 1'b0;
            if (job_taken && !load)
            begin
                done_reg <= 1'b1;
                stat_reg <= (job.kind == KIND_REJECT);
            end
            else if (rd_pend_reg)
            begin
                done_reg <= 1'b1;
                is_read_reg <= 1'b1;
            end
            else if (state_reg != BE_IDLE && state_next == BE_IDLE
                     && cur_reg.kind != KIND_READ)
                done_reg <= 1'b1;
        end
    end

    assign done = done_reg;
    assign status = stat_reg;
    assign pixel_value = is_read_reg ? rdata_reg : 32'd0;
endmodule
`default_nettype wire

@@ rtl/framebuffer_draw_engine.sv @@
`default_nettype none
// Raster fill engine over a row-major 32-bit frame store.
// Request channel: drive opcode and its fields with start high; the request is
// taken at a clock edge where start is high and busy is low.
// Configuration: cfg_we with cfg_index (0 width, 1 height) and cfg_data, only
// while idle. Zero acts as 1, values above the maximum act as the maximum.
// Result: done pulses for one cycle with pixel_value and status; it cannot be
// stalled. Every request gives exactly one result.
// Structure: a front stage classifies and bounds-checks a request and
// hands it through a one-entry queue to the drawing engine, which touches
// one pixel per cycle through the single memory port on a span or clear; an
// XOR line reads each pixel and then writes it back.
// Rejected and empty requests finish without touching the frame store.
// Reset clears control state and sets width and height to 512, capped at the
// maximum; the store has no reset value and unwritten pixels read as undefined.
module framebuffer_draw_engine #(
    parameter int unsigned MAX_WIDTH  = fbde_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = fbde_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [2:0]    opcode,
    input  wire logic [8:0]    pos_x,
    input  wire logic [8:0]    pos_y,
    input  wire logic [8:0]    end_coord,
    input  wire logic [9:0]    rect_width,
    input  wire logic [9:0]    rect_height,
    input  wire logic [31:0]   color,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [9:0]    cfg_data,
    output logic               done,
    output logic [31:0]        pixel_value,
    output logic               status
);
    import fbde_pkg::*;

    localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
    localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);

    logic [12:0] w_reg, h_reg, cfg_val;
    job_t job;
    logic job_valid, job_taken, accept, pending_reg;

    assign cfg_val = {3'd0, cfg_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= (MAXW < 13'd512) ? MAXW : 13'd512;
            h_reg <= (MAXH < 13'd512) ? MAXH : 13'd512;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0)
                w_reg <= (cfg_val == '0) ? 13'd1 : ((cfg_val > MAXW) ? MAXW : cfg_val);
            else
                h_reg <= (cfg_val == '0) ? 13'd1 : ((cfg_val > MAXH) ? MAXH : cfg_val);
        end
    end

    // one request in flight from acceptance until its result
    assign accept = start && !busy;
    assign busy = pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 1'b0;
        else if (accept)
            pending_reg <= 1'b1;
        else if (done)
            pending_reg <= 1'b0;
    end

    fbde_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(accept),
        .opcode(opcode), .pos_x(pos_x), .pos_y(pos_y), .end_coord(end_coord),
        .rect_width(rect_width), .rect_height(rect_height), .color(color),
        .img_w(w_reg), .img_h(h_reg),
        .job(job), .job_valid(job_valid), .job_taken(job_taken)
    );

    fbde_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .clk(clk), .rst_n(rst_n), .job(job), .job_valid(job_valid),
        .job_taken(job_taken), .img_w(w_reg),
        .done(done), .pixel_value(pixel_value), .status(status)
    );
endmodule
`default_nettype wire

@@ tb/sv/fbde_checker.sv @@
module fbde_checker
    import fbde_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [2:0]  opcode,
    input  wire logic [8:0]  pos_x,
    input  wire logic [8:0]  pos_y,
    input  wire logic [8:0]  end_coord,
    input  wire logic [9:0]  rect_width,
    input  wire logic [9:0]  rect_height,
    input  wire logic [31:0] color,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [9:0]  cfg_data,
    input  wire logic        done,
    input  wire logic [31:0] pixel_value,
    input  wire logic        status,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam bit REG_WIDTH = 1'b0;

    typedef struct packed {
        logic [31:0] pixel;
        logic        rejected;
    } draw_result_t;

    bit [31:0]    frame [DEPTH];
    int unsigned  img_w, img_h;
    draw_result_t expected_results[$];

    assign pending = expected_results.size();

    function automatic int unsigned clamp_dim(logic [9:0] v, int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic void put(int unsigned idx, bit [31:0] c, bit xr);
        if (idx < DEPTH)
            frame[idx] = xr ? (frame[idx] ^ c) : c;
    endfunction

    function automatic draw_result_t draw(op_t op, int unsigned px, int unsigned py,
                                          int unsigned pe, int unsigned rw,
                                          int unsigned rh, bit [31:0] c);
        draw_result_t r;
        int unsigned  base;
        r = '0;
        case (op)
            OP_CLEAR:
                for (int unsigned i = 0; i < img_w * img_h; i++)
                    put(i, c, 1'b0);
            OP_SET, OP_READ:
                if (px >= img_w || py >= img_h)
                    r.rejected = 1'b1;
                else if (op == OP_SET)
                    put(py * img_w + px, c, 1'b0);
                else
                    r.pixel = frame[py * img_w + px];
            OP_HLINE:
                if (px <= pe) begin
                    if (pe >= img_w || py >= img_h)
                        r.rejected = 1'b1;
                    else
                        for (int unsigned i = px; i <= pe; i++)
                            put(py * img_w + i, c, 1'b0);
                end
            OP_VLINE, OP_VXOR:
                if (py <= pe) begin
                    if (px >= img_w || pe >= img_h)
                        r.rejected = 1'b1;
                    else
                        for (int unsigned i = py; i <= pe; i++)
                            put(i * img_w + px, c, op == OP_VXOR);
                end
            OP_RECT:
                if (rw != 0 && rh != 0) begin
                    if (px + rw > img_w || py + rh > img_h)
                        r.rejected = 1'b1;
                    else begin
                        base = py * img_w + px;
                        for (int unsigned i = 0; i < rh; i++) begin
                            for (int unsigned j = 0; j < rw; j++)
                                put(base + j, c, 1'b0);
                            base += img_w;
                        end
                    end
                end
            default:
                r.rejected = 1'b1;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        draw_result_t want;
        if (!rst_n) begin
            img_w  = DEF_MAX_WIDTH;
            img_h  = DEF_MAX_HEIGHT;
            errors = 0;
            expected_results.delete();
        end else begin
            if (done) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (pixel_value !== want.pixel) begin
                        $error("pixel_value: expected %h, actual %h", want.pixel, pixel_value);
                        errors++;
                    end
                    if (status !== want.rejected) begin
                        $error("status: expected %0d, actual %0d", want.rejected, status);
                        errors++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_WIDTH)
                    img_w = clamp_dim(cfg_data, DEF_MAX_WIDTH);
                else
                    img_h = clamp_dim(cfg_data, DEF_MAX_HEIGHT);
            end
            if (start && !busy)
                expected_results.push_back(draw(op_t'(opcode), pos_x, pos_y, end_coord,
                                                rect_width, rect_height, color));
        end
    end
endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    import fbde_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit REG_WIDTH  = 1'b0;
    localparam bit REG_HEIGHT = 1'b1;

    logic        clk, rst_n, start, busy, done, status;
    logic [2:0]  opcode;
    logic [8:0]  pos_x, pos_y, end_coord;
    logic [9:0]  rect_width, rect_height, cfg_data;
    logic [31:0] color, pixel_value;
    logic        cfg_we, cfg_index;
    int          errors, pending;
    int unsigned geo_w, geo_h;
    bit          no_idle;

    framebuffer_draw_engine dut (.*);

    fbde_checker u_checker (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #200ms;
        $display("tb_top failed");
        $finish;
    end

    task automatic send(op_t op, int unsigned px, int unsigned py, int unsigned pe,
                        int unsigned rw, int unsigned rh, bit [31:0] c);
        if (!no_idle && $urandom_range(99) < 25) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start       <= 1'b1;
        opcode      <= op;
        pos_x       <= 9'(px);
        pos_y       <= 9'(py);
        end_coord   <= 9'(pe);
        rect_width  <= 10'(rw);
        rect_height <= 10'(rh);
        color       <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // hold off until every request has its result
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_geometry(logic [9:0] w, logic [9:0] h);
        drain();
        cfg_we <= 1'b1; cfg_index <= REG_WIDTH; cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_HEIGHT; cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        geo_w = (w == 0) ? 1 : (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
        geo_h = (h == 0) ? 1 : (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
    endtask

    task automatic random_request();
        op_t         op;
        int unsigned px, py, pe, rw, rh;
        bit          noise;
        op    = op_t'($urandom_range(1, 7));
        noise = $urandom_range(99) < 15;
        if ($urandom_range(99) < 3)
            op = OP_CLEAR;
        px = $urandom_range(geo_w - 1);
        py = $urandom_range(geo_h - 1);
        rw = $urandom_range(1, geo_w - px);
        rh = $urandom_range(1, geo_h - py);
        case (op)
            OP_HLINE: pe = $urandom_range(px, geo_w - 1);
            OP_VLINE, OP_VXOR: pe = $urandom_range(py, geo_h - 1);
            default: pe = $urandom_range(511);
        endcase
        if (noise) begin
            // broken spans and coordinates past the edge
            case ($urandom_range(3))
                0: begin px = $urandom_range(511); py = $urandom_range(511); end
                1: pe = $urandom_range(511);
                2: begin rw = $urandom_range(1023); rh = $urandom_range(1023); end
                default: begin rw = rw * $urandom_range(1); rh = rh * $urandom_range(1); end
            endcase
            // keep big in-range work bounded
            if (op == OP_RECT && px + rw <= geo_w && py + rh <= geo_h && rw * rh > 4096)
                rh = 0;
        end
        send(op, px, py, pe, rw, rh, $urandom());
    endtask

    initial begin
        logic [9:0] gw[6] = '{10'd40, 10'd1023, 10'd7, 10'd48, 10'd19, 10'd33};
        logic [9:0] gh[6] = '{10'd24, 10'd3, 10'd1000, 10'd16, 10'd1, 10'd21};
        rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        opcode = '0; pos_x = '0; pos_y = '0; end_coord = '0;
        rect_width = '0; rect_height = '0; color = '0;
        no_idle = 1'b0;
        geo_w = DEF_MAX_WIDTH;
        geo_h = DEF_MAX_HEIGHT;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole store first so no read ever sees an unwritten pixel
        send(OP_CLEAR, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send(OP_SET, 0, 0, 0, 0, 0, 32'h1234_5678);
        send(OP_SET, 511, 511, 0, 0, 0, 32'h0);
        send(OP_READ, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send(OP_READ, 511, 511, 511, 1023, 1023, 32'hFFFF_FFFF);
        send(OP_HLINE, 0, 511, 511, 0, 0, 32'hA5A5_5A5A);
        send(OP_VLINE, 511, 0, 511, 0, 0, 32'h0F0F_F0F0);
        send(OP_VXOR, 0, 0, 511, 0, 0, 32'hFFFF_0000);
        send(OP_HLINE, 6, 3, 5, 0, 0, 32'h1);
        send(OP_VLINE, 2, 9, 8, 0, 0, 32'h2);
        send(OP_RECT, 511, 0, 0, 1, 512, 32'hCAFE_BABE);
        send(OP_RECT, 0, 7, 0, 512, 1, 32'hDEAD_BEEF);
        send(OP_RECT, 1, 7, 0, 512, 1, 32'h3);
        send(OP_RECT, 3, 3, 0, 0, 5, 32'h4);
        send(OP_RECT, 3, 3, 0, 5, 0, 32'h5);
        send(OP_BAD, 1, 1, 1, 1, 1, 32'h6);
        send(OP_READ, 511, 0, 0, 0, 0, 0);
        send(OP_READ, 0, 7, 0, 0, 0, 0);
        set_geometry(10'd0, 10'd0);
        send(OP_SET, 1, 0, 0, 0, 0, 32'h7);
        send(OP_READ, 0, 1, 0, 0, 0, 0);
        send(OP_HLINE, 0, 0, 1, 0, 0, 32'h8);
        send(OP_VLINE, 300, 5, 3, 0, 0, 32'h9);
        send(OP_RECT, 0, 0, 0, 1, 1, 32'hA);
        send(OP_READ, 0, 0, 0, 0, 0, 0);

        for (int p = 0; p < 6; p++) begin
            set_geometry(gw[p], gh[p]);
            for (int n = 0; n < 96; n++) begin
                no_idle = (p == 2);
                if (p == 4 && n == 48)
                    drain();
                random_request();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/fbde_pkg.sv
rtl/fbde_front.sv
rtl/fbde_back.sv
rtl/framebuffer_draw_engine.sv
tb/sv/fbde_checker.sv
tb/sv/tb_top.sv
